// ===== src/positional_ordered_list_top_defines.svh =====
// Assertion macros for the positional ordered list.
`ifndef POSITIONAL_ORDERED_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define POL_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("pol assertion failed");
// checked on every edge, reset included
`define POL_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("pol assertion failed");
`else
`define POL_ASSERT(label, prop)
`define POL_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== src/pol_pkg.sv =====
// Shared types and constants of the positional ordered list.
package pol_pkg;

    localparam int DEPTH  = 32;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int ITEM_W = 6;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  item_value;
        logic [ITEM_W-1:0]        item_index;
        logic                     last;
        status_t                  status;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic apply;     // execute the accepted word, one result
        logic rd_start;  // begin a read out at entry 0
        logic rd_emit;   // emit the current entry, advance
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic rd_last;
        logic empty;
    } sts_t;

endpackage

// ===== src/pol_ctrl.sv =====
// Controller state machine of the positional ordered list.
module pol_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  pol_pkg::op_t  op,
    input  pol_pkg::sts_t sts,
    output logic          s_ready,
    output pol_pkg::cmd_t cmd
);
    import pol_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.apply    = 1'b0;
        cmd.rd_start = 1'b0;
        cmd.rd_emit  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (op == OP_READ && !sts.empty) begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_READ;
                    end else begin
                        cmd.apply = 1'b1;
                    end
                end
            end
            S_READ: begin
                cmd.rd_emit = sts.out_free;
                if (sts.out_free && sts.rd_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/pol_dp.sv =====
// Datapath of the positional ordered list: shifting cells, count, read index, result register.
module pol_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  pol_pkg::in_t  s_data,
    input  pol_pkg::cmd_t cmd,
    input  logic          m_ready,
    output pol_pkg::sts_t sts,
    output pol_pkg::out_t m_data,
    output logic          m_valid
);
    import pol_pkg::*;

    logic signed [VAL_W-1:0] entry_reg  [DEPTH];
    logic signed [VAL_W-1:0] entry_next [DEPTH];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]        rd_pos;
    out_t                    out_reg, out_next;
    logic                    valid_reg, valid_next;

    logic [CMP_W-1:0] pos_ext, cnt_ext;
    logic             full, empty, ins_ok, del_ok, do_ins, do_del;
    status_t          op_status;

    assign pos_ext = CMP_W'(s_data.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (cnt_ext == CMP_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign ins_ok  = !full && (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_ok  = !empty && (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign do_ins  = cmd.apply && (s_data.op == OP_INSERT) && ins_ok;
    assign do_del  = cmd.apply && (s_data.op == OP_DELETE) && del_ok;

    always_comb begin
        case (s_data.op)
            OP_INSERT: op_status = full ? ST_FULL : (ins_ok ? ST_OK : ST_RANGE);
            OP_DELETE: op_status = empty ? ST_EMPTY : (del_ok ? ST_OK : ST_RANGE);
            OP_READ:   op_status = ST_EMPTY;  // only a read of an empty list gets here
            OP_NONE:   op_status = ST_OK;
            default:   op_status = ST_OK;
        endcase
    end

    // each cell looks only at its neighbors and the incoming value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CMP_W-1:0] SLOT = CMP_W'(g + 1);
        logic signed [VAL_W-1:0] prev_w, succ_w;
        if (g == 0) begin : g_head
            assign prev_w = s_data.value;
        end else begin : g_body
            assign prev_w = entry_reg[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign succ_w = entry_reg[g];
        end else begin : g_inner
            assign succ_w = entry_reg[g+1];
        end
        assign entry_next[g] = (do_ins && SLOT == pos_ext) ? s_data.value :
                               (do_ins && SLOT >  pos_ext) ? prev_w :
                               (do_del && SLOT >= pos_ext) ? succ_w :
                               entry_reg[g];
    end

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign rd_pos = CNT_W'(rd_idx_reg) + CNT_W'(1);

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start) begin
            rd_idx_next = '0;
        end else if (cmd.rd_emit) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_next   = out_reg;
        valid_next = valid_reg && !m_ready;
        if (cmd.apply) begin
            out_next.item_value = '0;
            out_next.item_index = ITEM_W'(count_next);
            out_next.last       = 1'b1;
            out_next.status     = op_status;
            valid_next          = 1'b1;
        end else if (cmd.rd_emit) begin
            out_next.item_value = entry_reg[rd_idx_reg];
            out_next.item_index = ITEM_W'(rd_pos);
            out_next.last       = (rd_pos == count_reg);
            out_next.status     = ST_OK;
            valid_next          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= valid_next;
        end
    end

    assign sts.out_free = !valid_reg || m_ready;
    assign sts.rd_last  = (rd_pos == count_reg);
    assign sts.empty    = empty;
    assign m_data       = out_reg;
    assign m_valid      = valid_reg;

endmodule

// ===== src/positional_ordered_list_top.sv =====
// Top level of the positional ordered list: controller, datapath and checks.
//
// Holds up to 32 signed 32-bit entries in order. Insert, delete and an unused
// op code each produce one result word, registered in the cycle after the
// input word is taken; the whole list shifts in that same cycle. A read out
// loads one entry per cycle into the result register while that register is
// free or being drained (one result word for an empty list). The next input
// word is taken once the last result of the previous one has been loaded and
// the result register is free or being drained, so a steady insert/delete
// stream runs at one word per cycle while the result side keeps up, and a read
// out holds the input until its last entry is loaded. Rejected operations
// report a nonzero status and leave the list untouched.
`include "positional_ordered_list_top_defines.svh"

module positional_ordered_list_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pol_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pol_pkg::out_t m_data
);
    import pol_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .op      (s_data.op),
        .sts     (sts),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    pol_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_ready (m_ready),
        .sts     (sts),
        .m_data  (m_data),
        .m_valid (m_valid)
    );

    // at most one datapath command per cycle
    `POL_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.apply, cmd.rd_start, cmd.rd_emit}))
    // no input word is taken while a read out is streaming
    `POL_ASSERT_ALWAYS(a_no_accept_in_read, cmd.rd_emit |-> !s_ready)
    // a result is only loaded when the result register can take it
    `POL_ASSERT(a_load_when_free, (cmd.apply || cmd.rd_emit) |-> (!m_valid || m_ready))
    // a read out never starts on an empty list
    `POL_ASSERT(a_read_nonempty, cmd.rd_start |-> !sts.empty)

endmodule

// ===== test/pol_checker.sv =====
// Scoreboard for the positional ordered list: tracks the list, predicts and checks result words.
module pol_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  pol_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  pol_pkg::out_t m_data,
    output int            fail_count,
    output int            pending,
    output int            list_size
);
    import pol_pkg::*;

    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int   list_len = 0;
    int   errors = 0;
    int   waiting = 0;
    out_t expected_words [$];

    assign fail_count = errors;
    assign pending    = waiting;
    assign list_size  = list_len;

    function automatic out_t result_word(logic signed [VAL_W-1:0] v, int idx, logic lst,
                                         status_t st);
        out_t r;
        r.item_value = v;
        r.item_index = idx[ITEM_W-1:0];
        r.last       = lst;
        r.status     = st;
        return r;
    endfunction

    task automatic report(string field, longint exp_val, longint got_val);
        $error("%s mismatch: expected %0d, got %0d", field, exp_val, got_val);
        errors++;
    endtask

    // Applies one accepted word to the tracked list and queues its result words.
    task automatic apply_list_op(in_t w);
        int      pos;
        status_t st;
        pos = int'(w.position);
        case (w.op)
            OP_INSERT: begin
                // full is checked before the position
                if (list_len >= DEPTH) begin
                    st = ST_FULL;
                end else if (pos < 1 || pos > list_len + 1) begin
                    st = ST_RANGE;
                end else begin
                    for (int i = list_len; i >= pos; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos-1] = w.value;
                    list_len++;
                    st = ST_OK;
                end
                expected_words.push_back(result_word('0, list_len, 1'b1, st));
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (pos < 1 || pos > list_len) begin
                    st = ST_RANGE;
                end else begin
                    for (int i = pos - 1; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                    st = ST_OK;
                end
                expected_words.push_back(result_word('0, list_len, 1'b1, st));
            end
            OP_READ: begin
                if (list_len == 0) begin
                    expected_words.push_back(result_word('0, 0, 1'b1, ST_EMPTY));
                end else begin
                    for (int i = 0; i < list_len; i++)
                        expected_words.push_back(result_word(list_vals[i], i + 1,
                                                             (i + 1 == list_len), ST_OK));
                end
            end
            default: expected_words.push_back(result_word('0, list_len, 1'b1, ST_OK));
        endcase
    endtask

    always @(posedge aclk) begin
        out_t exp_word;
        if (!aresetn) begin
            list_len = 0;
            expected_words.delete();
        end else begin
            // result side first: a word accepted now belongs to an earlier input
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: %p", m_data);
                    errors++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (m_data.item_value !== exp_word.item_value)
                        report("item_value", exp_word.item_value, m_data.item_value);
                    if (m_data.item_index !== exp_word.item_index)
                        report("item_index", exp_word.item_index, m_data.item_index);
                    if (m_data.last !== exp_word.last)
                        report("last", exp_word.last, m_data.last);
                    if (m_data.status !== exp_word.status)
                        report("status", exp_word.status, m_data.status);
                end
            end
            if (s_valid && s_ready)
                apply_list_op(s_data);
        end
        waiting = expected_words.size();
    end

endmodule

// ===== test/tb_positional_ordered_list_top.sv =====
// Testbench top for the positional ordered list: stimulus, watchdog and verdict.
module tb_positional_ordered_list_top;
    import pol_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_LEN     = 56;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    int    fail_count;
    int    pending;
    int    list_size;
    int    idle_cycles = 0;
    bit    quiet = 1'b0;

    // insert / delete weights per random phase, the rest are read outs
    int    ins_weight [RANDOM_PHASES] = '{50, 85, 85, 10, 10, 45, 85, 15};
    int    del_weight [RANDOM_PHASES] = '{35, 5, 10, 80, 85, 45, 5, 75};

    always #5 aclk = ~aclk;

    positional_ordered_list_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pol_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .list_size  (list_size)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic in_t make_word(op_t op, int pos, logic signed [VAL_W-1:0] val);
        in_t w;
        w.op       = op;
        w.position = pos[POS_W-1:0];
        w.value    = val;
        return w;
    endfunction

    // Mostly legal positions, biased to both ends of the list; some noise words.
    function automatic in_t random_word(int ins_w, int del_w);
        in_t w;
        int  r;
        int  hi;
        r = $urandom_range(0, 99);
        if (r < 5)
            w.value = 32'h8000_0000;
        else if (r < 10)
            w.value = 32'h7fff_ffff;
        else
            w.value = $urandom;
        if ($urandom_range(0, 99) < 8) begin
            w.op       = op_t'($urandom_range(0, 3));
            w.position = POS_W'($urandom_range(0, 63));
            return w;
        end
        r = $urandom_range(0, 99);
        if (r < ins_w) begin
            w.op = OP_INSERT;
            hi   = list_size + 1;
        end else if (r < ins_w + del_w) begin
            w.op = OP_DELETE;
            hi   = (list_size == 0) ? 1 : list_size;
        end else begin
            w.op = OP_READ;
            hi   = 1;
        end
        case ($urandom_range(0, 3))
            0:       w.position = POS_W'(1);
            1:       w.position = POS_W'(hi);
            default: w.position = POS_W'($urandom_range(1, hi));
        endcase
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list corner cases
        send_word(make_word(OP_READ, 0, 0));
        send_word(make_word(OP_DELETE, 1, 0));
        send_word(make_word(OP_INSERT, 0, 1));
        send_word(make_word(OP_INSERT, 2, 2));
        send_word(make_word(OP_INSERT, 63, 3));
        // inserts at front, end and middle with extreme values
        send_word(make_word(OP_INSERT, 1, 32'h7fff_ffff));
        send_word(make_word(OP_INSERT, 1, 32'h8000_0000));
        send_word(make_word(OP_INSERT, 3, -1));
        send_word(make_word(OP_INSERT, 2, 0));
        send_word(make_word(OP_INSERT, 5, 32'h1234_5678));
        send_word(make_word(OP_READ, 63, -1));
        // bad delete positions, then last and first entries
        send_word(make_word(OP_DELETE, 0, 0));
        send_word(make_word(OP_DELETE, 6, 0));
        send_word(make_word(OP_DELETE, 5, 0));
        send_word(make_word(OP_DELETE, 1, 0));
        send_word(make_word(OP_NONE, 63, -1));
        send_word(make_word(OP_READ, 0, 0));
        send_word(make_word(OP_DELETE, 2, 0));
        send_word(make_word(OP_DELETE, 2, 0));
        // removing the only entry empties the list
        send_word(make_word(OP_DELETE, 1, 0));
        send_word(make_word(OP_READ, 0, 0));
        send_word(make_word(OP_INSERT, 1, 32'h5555_5555));
        send_word(make_word(OP_INSERT, 2, 32'haaaa_aaaa));
        send_word(make_word(OP_READ, 0, 0));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet = (p % 3 == 2);
            repeat (PHASE_LEN) send_word(random_word(ins_weight[p], del_weight[p]));
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
